/* hw/rtl/dsuf_pkg.sv */
// Package for the disjoint-set union-find block: field widths, item structs,
// memory request struct, sequencer states and register map.
// No dependencies; used by every module of the block.
package dsuf_pkg;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int SIZE_W  = 11;
    localparam int COUNT_W = 11;
    localparam int MERGE_W = 10;

    // Node ids span this many values, whatever the table depth
    localparam int ID_SPAN       = 2 ** NODE_W;
    localparam int NODES_DEFAULT = 1024;

    // Register map
    localparam int                  PADDR_W          = 3;
    localparam int                  PDATA_W          = 32;
    localparam int                  REG_IDX_W        = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT  = '0;
    localparam logic [COUNT_W-1:0]  NODE_COUNT_RESET = COUNT_W'(1024);

    // Input item
    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               joined;
        logic [NODE_W-1:0]  result_root;
        logic [COUNT_W-1:0] component_count;
    } t_out_item;

    // Read and write requests to the parent and size stores
    typedef struct packed {
        logic [NODE_W-1:0] p_raddr;
        logic              p_we;
        logic [NODE_W-1:0] p_waddr;
        logic [NODE_W-1:0] p_wdata;
        logic [NODE_W-1:0] s_raddr;
        logic              s_we;
        logic [NODE_W-1:0] s_waddr;
        logic [SIZE_W-1:0] s_wdata;
    } t_mem_req;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_P,
        S_FIND_GP,
        S_SIZE,
        S_LINK,
        S_OUT
    } t_state;

endpackage

/* hw/rtl/disjoint_set_union_find_top.sv */
// Top level of the disjoint-set union-find block: register port, sequencer, stores.
// Depends on dsuf_pkg, dsuf_cfg, dsuf_mem, dsuf_ctrl.
//
// Union-find over min(NODES, 1024) nodes with path halving and union by size.
// After reset the block runs a clearing pass over min(NODES, 1024) nodes that sets every
// node to a singleton; o_stall stays high until it ends (register writes are taken).
// One item is in work at a time; a new item is accepted only once the result of the
// last one has been taken. An item walks from node_a and then node_b to their roots; one
// that merges two sets then reads both root sizes and links, and an item naming a node
// beyond the table gets an unjoined result without any walk. Every hop uses the single
// parent-store read port, with registered read data, once for the parent and once for
// the grandparent. Writes to node_count at byte address 0 take effect on the next
// result's component_count.
module disjoint_set_union_find_top #(
    parameter int NODES = dsuf_pkg::NODES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  dsuf_pkg::t_in_item            i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output dsuf_pkg::t_out_item           o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsuf_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsuf_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsuf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dsuf_pkg::*;

    logic [COUNT_W-1:0] w_node_count;
    t_mem_req           w_req;
    logic [NODE_W-1:0]  w_parent;
    logic [SIZE_W-1:0]  w_size;

    // register port
    dsuf_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_node_count (w_node_count)
    );

    // parent and size stores
    dsuf_mem #(
        .NODES (NODES)
    ) u_mem (
        .i_clk    (i_clk),
        .i_req    (w_req),
        .o_parent (w_parent),
        .o_size   (w_size)
    );

    // sequencer
    dsuf_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .i_node_count (w_node_count),
        .o_req        (w_req),
        .i_parent     (w_parent),
        .i_size       (w_size)
    );

endmodule

/* hw/rtl/dsuf_cfg.sv */
// APB-style register port holding node_count.
// Depends on dsuf_pkg.
module dsuf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsuf_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsuf_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsuf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [dsuf_pkg::COUNT_W-1:0]  o_node_count
);
    import dsuf_pkg::*;

    logic [COUNT_W-1:0]   r_node_count;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // node_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (w_wr && (w_idx == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[COUNT_W-1:0];
        end
    end

    // read mux
    assign prdata = (w_idx == REG_NODE_COUNT) ? PDATA_W'(r_node_count) : '0;

    assign o_node_count = r_node_count;

endmodule

/* hw/rtl/dsuf_mem.sv */
// Parent and set-size stores, one write and one registered read port each.
// Depends on dsuf_pkg.
module dsuf_mem #(
    parameter int NODES = dsuf_pkg::NODES_DEFAULT
) (
    input  logic                         i_clk,
    input  dsuf_pkg::t_mem_req           i_req,
    output logic [dsuf_pkg::NODE_W-1:0]  o_parent,
    output logic [dsuf_pkg::SIZE_W-1:0]  o_size
);
    import dsuf_pkg::*;

    // ids never exceed the id span, so deeper tables would go unused
    localparam int DEPTH = (NODES < ID_SPAN) ? NODES : ID_SPAN;
    localparam int AW    = $clog2(DEPTH);

    logic [NODE_W-1:0] r_parent_mem [DEPTH];
    logic [SIZE_W-1:0] r_size_mem   [DEPTH];
    logic [NODE_W-1:0] r_parent_q;
    logic [SIZE_W-1:0] r_size_q;

    // parent store, read-first
    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_parent_mem[i_req.p_waddr[AW-1:0]] <= i_req.p_wdata;
        end
        r_parent_q <= r_parent_mem[i_req.p_raddr[AW-1:0]];
    end

    // size store, read-first
    always_ff @(posedge i_clk) begin
        if (i_req.s_we) begin
            r_size_mem[i_req.s_waddr[AW-1:0]] <= i_req.s_wdata;
        end
        r_size_q <= r_size_mem[i_req.s_raddr[AW-1:0]];
    end

    assign o_parent = r_parent_q;
    assign o_size   = r_size_q;

endmodule

/* hw/rtl/dsuf_ctrl.sv */
// Sequencer: clearing pass, find with path halving, link by size, result register.
// Depends on dsuf_pkg; drives the stores in dsuf_mem.
module dsuf_ctrl #(
    parameter int NODES = dsuf_pkg::NODES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  dsuf_pkg::t_in_item            i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output dsuf_pkg::t_out_item           o_data,
    input  logic [dsuf_pkg::COUNT_W-1:0]  i_node_count,
    output dsuf_pkg::t_mem_req            o_req,
    input  logic [dsuf_pkg::NODE_W-1:0]   i_parent,
    input  logic [dsuf_pkg::SIZE_W-1:0]   i_size
);
    import dsuf_pkg::*;

    localparam int               DEPTH    = (NODES < ID_SPAN) ? NODES : ID_SPAN;
    localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(DEPTH - 1);

    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_x, n_x;
    logic [NODE_W-1:0]  r_b, n_b;
    logic [NODE_W-1:0]  r_ra, n_ra;
    logic               r_phase, n_phase;
    logic [SIZE_W-1:0]  r_sa, n_sa;
    logic [MERGE_W-1:0] r_merge, n_merge;
    logic [NODE_W-1:0]  r_clr, n_clr;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_mem_req           w_req;
    logic               w_in_range;
    logic [MERGE_W-1:0] w_merge_inc;
    logic [COUNT_W-1:0] w_count_now;
    logic [COUNT_W-1:0] w_count_inc;
    logic [SIZE_W-1:0]  w_sum;
    logic               w_a_bigger;

    assign w_in_range  = (32'(i_data.node_a) < NODES) && (32'(i_data.node_b) < NODES);
    assign w_merge_inc = r_merge + 1'b1;

    // component count, saturating at one
    assign w_count_now = (COUNT_W'(r_merge) < i_node_count)
                       ? i_node_count - COUNT_W'(r_merge) : COUNT_W'(1);
    assign w_count_inc = (COUNT_W'(w_merge_inc) < i_node_count)
                       ? i_node_count - COUNT_W'(w_merge_inc) : COUNT_W'(1);

    // shared size adder and compare
    assign w_sum      = r_sa + i_size;
    assign w_a_bigger = r_sa > i_size;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_merge     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_merge     <= n_merge;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_b     <= n_b;
        r_ra    <= n_ra;
        r_phase <= n_phase;
        r_sa    <= n_sa;
        r_out   <= n_out;
    end

    // next state and store requests
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_b         = r_b;
        n_ra        = r_ra;
        n_phase     = r_phase;
        n_sa        = r_sa;
        n_merge     = r_merge;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_req       = '0;

        case (r_state)
            // every node its own singleton
            S_CLEAR: begin
                w_req.p_we    = 1'b1;
                w_req.p_waddr = r_clr;
                w_req.p_wdata = r_clr;
                w_req.s_we    = 1'b1;
                w_req.s_waddr = r_clr;
                w_req.s_wdata = SIZE_W'(1);
                n_clr         = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    if (w_in_range) begin
                        n_x           = i_data.node_a;
                        n_b           = i_data.node_b;
                        n_phase       = 1'b0;
                        w_req.p_raddr = i_data.node_a;
                        n_state       = S_FIND_P;
                    end else begin
                        n_out.joined          = 1'b0;
                        n_out.result_root     = '0;
                        n_out.component_count = w_count_now;
                        n_out_valid           = 1'b1;
                        n_state               = S_OUT;
                    end
                end
            end

            // parent of x is on the read port
            S_FIND_P: begin
                if (i_parent == r_x) begin
                    if (!r_phase) begin
                        n_ra          = r_x;
                        n_x           = r_b;
                        n_phase       = 1'b1;
                        w_req.p_raddr = r_b;
                    end else if (r_x == r_ra) begin
                        n_out.joined          = 1'b0;
                        n_out.result_root     = r_x;
                        n_out.component_count = w_count_now;
                        n_out_valid           = 1'b1;
                        n_state               = S_OUT;
                    end else begin
                        w_req.s_raddr = r_ra;
                        n_state       = S_SIZE;
                    end
                end else begin
                    w_req.p_raddr = i_parent;
                    n_state       = S_FIND_GP;
                end
            end

            // grandparent on the read port: halve the path
            S_FIND_GP: begin
                w_req.p_we    = 1'b1;
                w_req.p_waddr = r_x;
                w_req.p_wdata = i_parent;
                w_req.p_raddr = i_parent;
                n_x           = i_parent;
                n_state       = S_FIND_P;
            end

            // size of root a on the port; fetch root b's
            S_SIZE: begin
                n_sa          = i_size;
                w_req.s_raddr = r_x;
                n_state       = S_LINK;
            end

            // smaller set under larger; tie puts a under b
            S_LINK: begin
                w_req.p_we    = 1'b1;
                w_req.s_we    = 1'b1;
                w_req.s_wdata = w_sum;
                if (w_a_bigger) begin
                    w_req.p_waddr     = r_x;
                    w_req.p_wdata     = r_ra;
                    w_req.s_waddr     = r_ra;
                    n_out.result_root = r_ra;
                end else begin
                    w_req.p_waddr     = r_ra;
                    w_req.p_wdata     = r_x;
                    w_req.s_waddr     = r_x;
                    n_out.result_root = r_x;
                end
                n_merge               = w_merge_inc;
                n_out.joined          = 1'b1;
                n_out.component_count = w_count_inc;
                n_out_valid           = 1'b1;
                n_state               = S_OUT;
            end

            S_OUT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_req   = w_req;

    // merge count moves only on a link
    a_merge_only_on_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LINK) |=> $stable(r_merge))
        else $error("merge count changed outside link");

    // linking only ever joins two distinct roots
    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_x != r_ra))
        else $error("link of a root with itself");

    // a link always produces a joined result
    a_link_joined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (o_valid && o_data.joined))
        else $error("link without joined result");

    // stores untouched while idle or holding a result
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> (!w_req.p_we && !w_req.s_we))
        else $error("store write while idle");

    // result valid exactly while in the output state
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == (r_state == S_OUT))
        else $error("result valid out of step with sequencer");

endmodule
